@@ rtl/core/okrgb_pkg.sv @@
// ----------------------------------------------------------------------------
// okrgb_pkg
// Types, fixed-point widths and matrix coefficients shared by the OKLab to
// 8-bit RGBA converter.
// ----------------------------------------------------------------------------
`default_nettype none

package okrgb_pkg;

  typedef struct packed {
    logic        [15:0] lightness;
    logic signed [15:0] green_red_axis;
    logic signed [15:0] blue_yellow_axis;
    logic        [7:0]  opacity_in;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] opacity_out;
    logic       clipped;
  } color_t;

  localparam int FRAC   = 20;  // fraction bits of l', m', s', cubes, channels
  localparam int COEF_W = 34;  // Q.30 coefficient, signed
  localparam int SUM1_W = 50;  // Q.45 sum of the first matrix
  localparam int Q20_W  = 24;  // l', m', s' in Q.20
  localparam int SQ_W   = 26;  // square in Q.20
  localparam int CUBE_W = 28;  // cube in Q.20
  localparam int PROD2_W = COEF_W + CUBE_W;  // Q.50 product
  localparam int SUM2_W = 64;  // Q.50 sum of the second matrix
  localparam int CH_W   = 32;  // channel in Q.20

  // Q.30 coefficient from a value in units of 1e-10, rounded to nearest.
  function automatic logic signed [COEF_W-1:0] qcoef(input logic [63:0] u);
    logic [63:0] q;
    q = (u * 64'd1048576 + 64'd4882812) / 64'd9765625;
    return $signed(q[COEF_W-1:0]);
  endfunction

  localparam logic signed [COEF_W-1:0] K_LA = qcoef(64'd3963377774);
  localparam logic signed [COEF_W-1:0] K_LB = qcoef(64'd2158037573);
  localparam logic signed [COEF_W-1:0] K_MA = qcoef(64'd1055613458);
  localparam logic signed [COEF_W-1:0] K_MB = qcoef(64'd638541728);
  localparam logic signed [COEF_W-1:0] K_SA = qcoef(64'd894841775);
  localparam logic signed [COEF_W-1:0] K_SB = qcoef(64'd12914855480);

  localparam logic signed [COEF_W-1:0] K_RL = qcoef(64'd40767416621);
  localparam logic signed [COEF_W-1:0] K_RM = qcoef(64'd33077115913);
  localparam logic signed [COEF_W-1:0] K_RS = qcoef(64'd2309699292);
  localparam logic signed [COEF_W-1:0] K_GL = qcoef(64'd12684380046);
  localparam logic signed [COEF_W-1:0] K_GM = qcoef(64'd26097574011);
  localparam logic signed [COEF_W-1:0] K_GS = qcoef(64'd3413193965);
  localparam logic signed [COEF_W-1:0] K_BL = qcoef(64'd41960863);
  localparam logic signed [COEF_W-1:0] K_BM = qcoef(64'd7034186147);
  localparam logic signed [COEF_W-1:0] K_BS = qcoef(64'd17076147010);

  // rows l', m', s'; columns a, b
  localparam logic signed [COEF_W-1:0] MIX1 [3][2] = '{
    '{ K_LA,  K_LB},
    '{-K_MA, -K_MB},
    '{-K_SA, -K_SB}
  };

  // rows red, green, blue; columns l, m, s cubes
  localparam logic signed [COEF_W-1:0] MIX2 [3][3] = '{
    '{ K_RL, -K_RM,  K_RS},
    '{-K_GL,  K_GM, -K_GS},
    '{-K_BL, -K_BM,  K_BS}
  };

endpackage

`default_nettype wire

@@ rtl/core/okrgb_cube.sv @@
// ----------------------------------------------------------------------------
// okrgb_cube
// Two-stage Q.20 cube: square rounded to Q.20, then times the input again,
// rounded to Q.20 (round half up).
// ----------------------------------------------------------------------------
`default_nettype none

module okrgb_cube
  import okrgb_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [Q20_W-1:0]  x,
  output      logic signed [CUBE_W-1:0] cube
);

  localparam int SQP_W = 2 * Q20_W;
  localparam int CBP_W = SQ_W + Q20_W;
  localparam logic signed [SQP_W-1:0] HALF_SQ = SQP_W'(2 ** (FRAC - 1));
  localparam logic signed [CBP_W-1:0] HALF_CB = CBP_W'(2 ** (FRAC - 1));

  logic signed [SQP_W-1:0]  sq_full;
  logic signed [CBP_W-1:0]  cube_full;
  logic signed [SQ_W-1:0]   sq;
  logic signed [Q20_W-1:0]  x_d;

  assign sq_full   = SQP_W'(x) * SQP_W'(x) + HALF_SQ;
  assign cube_full = CBP_W'(sq) * CBP_W'(x_d) + HALF_CB;

  always_ff @(posedge clk) begin
    sq   <= $signed(sq_full[FRAC +: SQ_W]);
    x_d  <= x;
    cube <= $signed(cube_full[FRAC +: CUBE_W]);
  end

endmodule

`default_nettype wire

@@ rtl/core/okrgb_byte.sv @@
// ----------------------------------------------------------------------------
// okrgb_byte
// Scale a Q.20 channel by 255, truncate toward zero and saturate to a byte,
// flagging saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module okrgb_byte
  import okrgb_pkg::*;
(
  input  wire logic signed [CH_W-1:0] ch,
  output      logic        [7:0]      value,
  output      logic                   clip
);

  localparam int VW = CH_W + 8;
  localparam logic signed [VW-1:0] NEG_ONE = -VW'(2 ** FRAC);

  logic signed [VW-1:0] v;

  assign v = (VW'(ch) <<< 8) - VW'(ch);

  always_comb begin
    if (v[VW-1]) begin
      value = 8'd0;
      clip  = (v <= NEG_ONE);
    end else if (|v[VW-2:FRAC+8]) begin
      value = 8'd255;
      clip  = 1'b1;
    end else begin
      value = v[FRAC +: 8];
      clip  = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/oklab_to_rgb8_converter.sv @@
// ----------------------------------------------------------------------------
// oklab_to_rgb8_converter
// OKLab pixel to linear 8-bit RGBA, fixed-point, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one pixel per clock: busy is never asserted, so every cycle with
// start high is a transaction. Each result appears on color with done high
// for exactly one cycle, in input order; the receiver cannot stall the
// block and must take it then. The seven register stages are: first-matrix
// products, l'/m'/s' sums, square, cube, second-matrix products, channel
// sums, byte scaling and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module oklab_to_rgb8_converter
  import okrgb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  input  wire pixel_t pixel,
  output      logic   busy,
  output      logic   done,
  output      color_t color
);

  localparam int LAT = 7;
  localparam logic signed [SUM1_W-1:0] HALF_Q45 = SUM1_W'(2 ** 24);
  localparam logic signed [SUM2_W-1:0] HALF_Q50 = SUM2_W'(2 ** 29);

  logic [LAT-1:0] vld;

  logic [7:0]               alpha_pipe [LAT-1];
  logic [15:0]              light1;
  logic signed [SUM1_W-1:0] prod1 [3][2];
  logic signed [SUM1_W-1:0] sum1  [3];
  logic signed [Q20_W-1:0]  lms   [3];
  logic signed [CUBE_W-1:0] lms_cube [3];
  logic signed [PROD2_W-1:0] prod2 [3][3];
  logic signed [SUM2_W-1:0] sum2  [3];
  logic signed [CH_W-1:0]   chan  [3];
  logic [7:0]               chan_byte [3];
  logic                     chan_clip [3];

  assign busy = 1'b0;
  assign done = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum1[i] = $signed({4'b0, light1, 30'b0}) + prod1[i][0] + prod1[i][1] + HALF_Q45;
      sum2[i] = SUM2_W'(prod2[i][0]) + SUM2_W'(prod2[i][1]) + SUM2_W'(prod2[i][2])
                + HALF_Q50;
    end
  end

  always_ff @(posedge clk) begin
    alpha_pipe[0] <= pixel.opacity_in;
    for (int s = 1; s < LAT - 1; s++) begin
      alpha_pipe[s] <= alpha_pipe[s-1];
    end
    light1 <= pixel.lightness;
    for (int i = 0; i < 3; i++) begin
      prod1[i][0] <= SUM1_W'(MIX1[i][0]) * SUM1_W'($signed(pixel.green_red_axis));
      prod1[i][1] <= SUM1_W'(MIX1[i][1]) * SUM1_W'($signed(pixel.blue_yellow_axis));
      lms[i]      <= $signed(sum1[i][25 +: Q20_W]);
      for (int j = 0; j < 3; j++) begin
        prod2[i][j] <= PROD2_W'(MIX2[i][j]) * PROD2_W'(lms_cube[j]);
      end
      chan[i] <= $signed(sum2[i][30 +: CH_W]);
    end
    color.red         <= chan_byte[0];
    color.green       <= chan_byte[1];
    color.blue        <= chan_byte[2];
    color.opacity_out <= alpha_pipe[LAT-2];
    color.clipped     <= chan_clip[0] | chan_clip[1] | chan_clip[2];
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    okrgb_cube u_cube (
      .clk  (clk),
      .x    (lms[g]),
      .cube (lms_cube[g])
    );

    okrgb_byte u_byte (
      .ch    (chan[g]),
      .value (chan_byte[g]),
      .clip  (chan_clip[g])
    );
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("transaction did not produce a result after the pipeline latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching transaction");

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    done |-> (color.opacity_out == $past(pixel.opacity_in, LAT)))
    else $error("alpha lost alignment with its pixel");

  a_clip_bound: assert property (@(posedge clk) disable iff (rst)
    (done && !color.clipped) |->
      ((color.red != 8'd255 || !$past(chan_clip[0])) &&
       (color.green != 8'd255 || !$past(chan_clip[1]))))
    else $error("saturated channel without clip flag");

endmodule

`default_nettype wire
